// File: src/kts_pkg.sv
`timescale 1ns / 1ps
package kts_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;
    localparam int VERTEX_W         = 6;
    localparam int VCOUNT_W         = 7;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SORT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CYCLE = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic [VERTEX_W-1:0] src_vertex;
        logic [VERTEX_W-1:0] dst_vertex;
    } t_in_item;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [1:0]          status;
        logic                last;
    } t_out_item;

endpackage

// File: src/kahn_topological_sort.sv
`timescale 1ns / 1ps
// Topological sort engine. Add-edge and clear items are taken one per cycle. A sort
// item first clears the in-degrees and recounts them over the stored edges whose
// endpoints are both in use, seeds the ready queue with the vertices of in-degree
// zero, then for every placed vertex walks the whole edge list, and finally emits n
// results, or one status result (cycle, or drop straight away when an add-edge was
// dropped). The steps run in turn, as the edge, in-degree and queue memories each
// have a single read port; no item is taken during a sort.
module kahn_topological_sort #(
    parameter int MAX_VERTICES = kts_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kts_pkg::DEF_MAX_EDGES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kts_pkg::VCOUNT_W-1:0]    i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  kts_pkg::t_in_item               i_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output kts_pkg::t_out_item              o_result
);
    import kts_pkg::*;

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam logic [VCOUNT_W-1:0] MAXV = VCOUNT_W'(MAX_VERTICES);
    localparam logic [ECW-1:0]      MAXE = ECW'(MAX_EDGES);

    localparam logic [3:0] S_IDLE = 4'd0,  S_CLR = 4'd1,  S_CNT_RD = 4'd2,  S_CNT_DEG = 4'd3;
    localparam logic [3:0] S_CNT_WR = 4'd4, S_SEED_RD = 4'd5, S_SEED_CHK = 4'd6;
    localparam logic [3:0] S_POP_RD = 4'd7, S_POP_GET = 4'd8, S_SCAN_RD = 4'd9;
    localparam logic [3:0] S_SCAN_CHK = 4'd10, S_SCAN_WR = 4'd11, S_DONE = 4'd12;
    localparam logic [3:0] S_EMIT_RD = 4'd13, S_EMIT_WAIT = 4'd14, S_FINAL = 4'd15;

    logic [3:0]          r_state, n_state;
    logic [VCOUNT_W-1:0] r_vcount;
    logic [ECW-1:0]      r_etotal, n_etotal;
    logic                r_drop, n_drop;
    logic [ECW-1:0]      r_eidx, n_eidx;
    logic [VCW-1:0]      r_idx, n_idx;
    logic [VCW-1:0]      r_head, n_head;
    logic [VCW-1:0]      r_tail, n_tail;
    logic [VERTEX_W-1:0] r_u, n_u;
    logic [VERTEX_W-1:0] r_tgt, n_tgt;
    logic [1:0]          r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic [VCOUNT_W-1:0] nv;
    logic                out_free;

    logic                    e_we, e_re;
    logic [EAW-1:0]          e_waddr, e_raddr;
    logic [2*VERTEX_W-1:0]   e_wdata, e_rdata;
    logic [VERTEX_W-1:0]     e_src, e_dst;
    logic                    d_we, d_re;
    logic [VAW-1:0]          d_waddr, d_raddr;
    logic [ECW-1:0]          d_wdata, d_rdata;
    logic                    f_we, f_re;
    logic [VAW-1:0]          f_waddr, f_raddr;
    logic [VERTEX_W-1:0]     f_wdata, f_rdata;

    kts_ram #(.WIDTH(2 * VERTEX_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_re(e_re), .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    kts_ram #(.WIDTH(ECW), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_re(d_re), .i_raddr(d_raddr), .o_rdata(d_rdata)
    );
    kts_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_fifo_ram (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_re(f_re), .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    assign e_src    = e_rdata[2*VERTEX_W-1:VERTEX_W];
    assign e_dst    = e_rdata[VERTEX_W-1:0];
    assign nv       = (r_vcount == '0) ? VCOUNT_W'(1) : ((r_vcount > MAXV) ? MAXV : r_vcount);
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state     = r_state;
        n_etotal    = r_etotal;
        n_drop      = r_drop;
        n_eidx      = r_eidx;
        n_idx       = r_idx;
        n_head      = r_head;
        n_tail      = r_tail;
        n_u         = r_u;
        n_tgt       = r_tgt;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        e_we = 1'b0; e_re = 1'b0;
        e_waddr = r_etotal[EAW-1:0];
        e_wdata = {i_item.src_vertex, i_item.dst_vertex};
        e_raddr = r_eidx[EAW-1:0];
        d_we = 1'b0; d_re = 1'b0;
        d_waddr = r_idx[VAW-1:0];
        d_wdata = '0;
        d_raddr = r_idx[VAW-1:0];
        f_we = 1'b0; f_re = 1'b0;
        f_waddr = r_tail[VAW-1:0];
        f_wdata = VERTEX_W'(r_idx);
        f_raddr = r_head[VAW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_item.op)
                        OP_ADD: begin
                            if ((VCOUNT_W'(i_item.src_vertex) >= nv) ||
                                (VCOUNT_W'(i_item.dst_vertex) >= nv) ||
                                (r_etotal == MAXE)) begin
                                n_drop = 1'b1;
                            end else begin
                                e_we     = 1'b1;
                                n_etotal = r_etotal + ECW'(1);
                            end
                        end
                        OP_SORT: begin
                            if (r_drop) begin
                                n_status = ST_DROP;
                                n_state  = S_FINAL;
                            end else begin
                                n_idx   = '0;
                                n_state = S_CLR;
                            end
                        end
                        OP_CLEAR: begin
                            n_etotal = '0;
                            n_drop   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLR: begin
                if (VCOUNT_W'(r_idx) == nv) begin
                    n_eidx  = '0;
                    n_state = S_CNT_RD;
                end else begin
                    d_we  = 1'b1;
                    n_idx = r_idx + VCW'(1);
                end
            end
            S_CNT_RD: begin
                if (r_eidx == r_etotal) begin
                    n_idx   = '0;
                    n_tail  = '0;
                    n_state = S_SEED_RD;
                end else begin
                    e_re    = 1'b1;
                    n_state = S_CNT_DEG;
                end
            end
            S_CNT_DEG: begin
                n_tgt = e_dst;
                if ((VCOUNT_W'(e_src) < nv) && (VCOUNT_W'(e_dst) < nv)) begin
                    d_re    = 1'b1;
                    d_raddr = e_dst[VAW-1:0];
                    n_state = S_CNT_WR;
                end else begin
                    n_eidx  = r_eidx + ECW'(1);
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_WR: begin
                d_we    = 1'b1;
                d_waddr = r_tgt[VAW-1:0];
                d_wdata = d_rdata + ECW'(1);
                n_eidx  = r_eidx + ECW'(1);
                n_state = S_CNT_RD;
            end
            S_SEED_RD: begin
                if (VCOUNT_W'(r_idx) == nv) begin
                    n_head  = '0;
                    n_state = S_POP_RD;
                end else begin
                    d_re    = 1'b1;
                    n_state = S_SEED_CHK;
                end
            end
            S_SEED_CHK: begin
                if (d_rdata == '0) begin
                    f_we   = 1'b1;
                    n_tail = r_tail + VCW'(1);
                end
                n_idx   = r_idx + VCW'(1);
                n_state = S_SEED_RD;
            end
            S_POP_RD: begin
                if (r_head == r_tail) begin
                    n_state = S_DONE;
                end else begin
                    f_re    = 1'b1;
                    n_head  = r_head + VCW'(1);
                    n_state = S_POP_GET;
                end
            end
            S_POP_GET: begin
                n_u     = f_rdata;
                n_eidx  = '0;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (r_eidx == r_etotal) begin
                    n_state = S_POP_RD;
                end else begin
                    e_re    = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                n_tgt  = e_dst;
                n_eidx = r_eidx + ECW'(1);
                if ((e_src == r_u) && (VCOUNT_W'(e_dst) < nv)) begin
                    d_re    = 1'b1;
                    d_raddr = e_dst[VAW-1:0];
                    n_state = S_SCAN_WR;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_WR: begin
                if (d_rdata != '0) begin
                    d_we    = 1'b1;
                    d_waddr = r_tgt[VAW-1:0];
                    d_wdata = d_rdata - ECW'(1);
                    if (d_rdata == ECW'(1)) begin
                        f_we    = 1'b1;
                        f_wdata = r_tgt;
                        n_tail  = r_tail + VCW'(1);
                    end
                end
                n_state = S_SCAN_RD;
            end
            S_DONE: begin
                if (VCOUNT_W'(r_tail) == nv) begin
                    n_idx   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_status = ST_CYCLE;
                    n_state  = S_FINAL;
                end
            end
            S_EMIT_RD: begin
                f_re    = 1'b1;
                f_raddr = r_idx[VAW-1:0];
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.vertex = f_rdata;
                    n_out.status = ST_OK;
                    n_out.last   = (VCOUNT_W'(r_idx) + VCOUNT_W'(1) == nv);
                    n_idx        = r_idx + VCW'(1);
                    n_state      = n_out.last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.vertex = '0;
                    n_out.status = r_status;
                    n_out.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= VCOUNT_RESET;
            r_etotal    <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_etotal    <= n_etotal;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx   <= n_eidx;
        r_idx    <= n_idx;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_u      <= n_u;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        r_out    <= n_out;
    end
endmodule

// File: src/kts_ram.sv
`timescale 1ns / 1ps
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
